>>> rtl/drd_pkg.sv
// Shared types, codes and reset constants of the delta/reuse decision block.
package drd_pkg;

  localparam int ValueW   = 32;
  localparam int ThrW     = 17;
  localparam int CountW   = 10;
  localparam int CfgIdxW  = 2;
  localparam int FracBits = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MATCH_TOL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REUSE_THR = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DELTA_THR = 2'd2;

  // Register values after reset (tolerance ~1e-4 in Q8.24, thresholds ~0.999 and ~0.90 in Q1.16)
  localparam logic [ValueW-1:0] TOL_RESET   = 32'd1678;
  localparam logic [ThrW-1:0]   REUSE_RESET = 17'd65470;
  localparam logic [ThrW-1:0]   DELTA_RESET = 17'd58982;

  typedef enum logic [1:0] {
    DEC_FULL  = 2'd0,
    DEC_DELTA = 2'd1,
    DEC_REUSE = 2'd2
  } decision_t;

  typedef struct packed {
    logic                     kind;
    logic [2:0]               layer;
    logic signed [ValueW-1:0] value;
    logic                     last;
  } elem_t;

  typedef struct packed {
    decision_t         decision;
    logic [CountW-1:0] match_count;
    logic [CountW-1:0] element_count;
  } result_t;

  // Per-beat control carried from the front end into the compare stage
  typedef struct packed {
    logic eligible;
    logic emit;
    logic known;
    logic last;
  } elem_ctl_t;

endpackage

>>> rtl/drd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module drd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/drd_match.sv
// Compare stage: tolerance check against the stored element and run match count.
module drd_match import drd_pkg::*; #(
  parameter int IW = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  elem_ctl_t         ld_ctl,
  input  logic [ValueW-1:0] ld_value,
  input  logic [IW-1:0]     ld_count,
  input  logic [ValueW-1:0] ref_value,
  input  logic [ValueW-1:0] tolerance,
  input  logic              take,
  output logic              free,
  output logic              sum_valid,
  output logic [IW-1:0]     sum_matches,
  output logic [IW-1:0]     sum_count,
  output logic              sum_known
);

  logic              s1_valid;
  elem_ctl_t         s1_ctl;
  logic [ValueW-1:0] s1_value;
  logic [IW-1:0]     s1_count;
  logic [IW-1:0]     acc;

  logic              go;
  logic signed [ValueW:0] diff;
  logic [ValueW:0]   mag;
  logic              hit;
  logic [IW-1:0]     hit_total;

  // A non-reporting beat leaves at once; a reporting one waits for the ratio stage
  assign go   = s1_valid && (!s1_ctl.emit || take);
  assign free = !s1_valid || go;

  assign diff = $signed({s1_value[ValueW-1], s1_value})
              - $signed({ref_value[ValueW-1], ref_value});
  assign mag  = diff[ValueW] ? $unsigned(-diff) : $unsigned(diff);
  assign hit  = s1_ctl.eligible && (mag <= {1'b0, tolerance});
  assign hit_total = acc + IW'(hit);

  assign sum_valid   = s1_valid && s1_ctl.emit;
  assign sum_matches = hit_total;
  assign sum_count   = s1_count;
  assign sum_known   = s1_ctl.known;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      acc      <= '0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (go) begin
        s1_valid <= 1'b0;
      end
      if (go) begin
        acc <= s1_ctl.last ? '0 : hit_total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_ctl   <= ld_ctl;
      s1_value <= ld_value;
      s1_count <= ld_count;
    end
  end

  // Matches can never outrun the elements counted in the same run
  a_acc_bounded: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ctl.emit) |-> (hit_total <= s1_count))
    else $error("match count exceeds element count");

endmodule

>>> rtl/drd_decide.sv
// Ratio stage: cross-multiplied threshold tests and the result register.
module drd_decide import drd_pkg::*; #(
  parameter int IW = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            sum_valid,
  input  logic [IW-1:0]   sum_matches,
  input  logic [IW-1:0]   sum_count,
  input  logic            sum_known,
  input  logic [ThrW-1:0] reuse_limit,
  input  logic [ThrW-1:0] delta_limit,
  output logic            take,
  output logic            result_valid,
  input  logic            result_ready,
  output result_t         result
);

  localparam int PW = ThrW + IW;

  logic          s2_valid;
  logic          s2_known;
  logic [IW-1:0] s2_m;
  logic [IW-1:0] s2_n;
  logic [PW-1:0] s2_scaled;
  logic [PW-1:0] s2_reuse_prod;
  logic [PW-1:0] s2_delta_prod;
  logic          out_load;
  decision_t     dec;

  assign out_load = s2_valid && (!result_valid || result_ready);
  assign take     = !s2_valid || out_load;

  always_comb begin
    dec = DEC_FULL;
    if (s2_known) begin
      if (s2_scaled >= s2_reuse_prod) begin
        dec = DEC_REUSE;
      end else if (s2_scaled >= s2_delta_prod) begin
        dec = DEC_DELTA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (sum_valid && take) begin
        s2_valid <= 1'b1;
      end else if (out_load) begin
        s2_valid <= 1'b0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && take) begin
      s2_known      <= sum_known;
      s2_m          <= sum_matches;
      s2_n          <= sum_count;
      s2_scaled     <= PW'(sum_matches) << FracBits;
      s2_reuse_prod <= PW'(reuse_limit) * PW'(sum_count);
      s2_delta_prod <= PW'(delta_limit) * PW'(sum_count);
    end
    if (out_load) begin
      result.decision      <= dec;
      result.match_count   <= CountW'(s2_m);
      result.element_count <= CountW'(s2_n);
    end
  end

  a_m_le_n: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_m <= s2_n))
    else $error("ratio stage holds more matches than elements");

  a_unknown_full: assert property (@(posedge clk) disable iff (rst)
    (out_load && !s2_known) |=> (result.decision == DEC_FULL))
    else $error("layer without a stored vector did not give FULL");

endmodule

>>> rtl/delta_reuse_decision.sv
// Top level of the per-layer activation reuse check: run tracking, layer table, store.
//
// Elements arrive on the elem channel (valid/ready), one beat per element, each
// tagged with kind, layer and last. A commit run (kind 1) writes its elements
// into the layer's reference store and, on its last beat, records the run length
// and marks the layer valid. A compare run (kind 0) checks each element against
// the stored one and, on its last beat, yields one result beat on the result
// channel: FULL, DELTA or REUSE plus match and element counts. Commit runs and
// non-final beats produce nothing.
// Throughput: one element per clock unless the result path stalls; the single
// read port of the reference store is used at most once per compare beat, only
// inside the committed length. A compare run's result passes through the store
// read, then the ratio multiply, then the result register.
// When the receiver stalls, the result register holds its beat and a second
// finished result waits in the ratio stage; elements keep flowing until the final
// beat of a third compare run reaches the compare stage, where it is held and elem_ready
// stays low until the ratio stage frees up.
// Reset clears the run position, layer valid bits and lengths and restores the
// configuration defaults; store contents are not cleared, as they are only read
// below a committed length. Write configuration only while the block is idle.
module delta_reuse_decision import drd_pkg::*; #(
  parameter int LAYER_COUNT  = 8,
  parameter int MAX_ELEMENTS = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               elem_valid,
  output logic               elem_ready,
  input  elem_t              elem,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ValueW-1:0]  cfg_data
);

  localparam int IW    = $clog2(MAX_ELEMENTS + 1);
  localparam int LW    = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int LIW   = (LW > 3) ? LW : 3;
  localparam int DEPTH = LAYER_COUNT * MAX_ELEMENTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers
  logic [ValueW-1:0] match_tolerance;
  logic [ThrW-1:0]   reuse_limit;
  logic [ThrW-1:0]   delta_limit;

  // Run and layer state
  logic [IW-1:0]          run_index;
  logic [LAYER_COUNT-1:0] reference_valid;
  logic [IW-1:0]          reference_length [LAYER_COUNT];

  logic              accept;
  logic [LIW-1:0]    layer_w;
  logic [LW-1:0]     layer_idx;
  logic              layer_ok;
  logic              in_range;
  logic [IW-1:0]     count_next;
  logic              ref_valid;
  logic [IW-1:0]     ref_len;
  elem_ctl_t         ctl;
  logic [AW-1:0]     store_addr;
  logic              store_we;
  logic              store_re;
  logic [ValueW-1:0] store_rdata;

  logic              sum_take;
  logic              sum_valid;
  logic [IW-1:0]     sum_matches;
  logic [IW-1:0]     sum_count;
  logic              sum_known;

  assign accept    = elem_valid && elem_ready;
  assign layer_w   = LIW'(elem.layer);
  assign layer_idx = layer_w[LW-1:0];
  assign layer_ok  = (32'(elem.layer) < 32'(LAYER_COUNT));

  // Saturate the run position: beats past the store depth are dropped
  assign in_range   = run_index < IW'(MAX_ELEMENTS);
  assign count_next = in_range ? run_index + IW'(1) : run_index;

  assign ref_valid = reference_valid[layer_idx];
  assign ref_len   = reference_length[layer_idx];

  // Compare only inside the committed length of a valid layer; anything else
  // is a mismatch. An unknown layer reports FULL whatever was counted.
  assign ctl.eligible = !elem.kind && layer_ok && ref_valid && in_range
                     && (run_index < ref_len);
  assign ctl.emit     = elem.last && !elem.kind;
  assign ctl.known    = layer_ok && ref_valid;
  assign ctl.last     = elem.last;

  assign store_addr = AW'(layer_idx) * AW'(MAX_ELEMENTS) + AW'(run_index);
  assign store_we   = accept && elem.kind && layer_ok && in_range;
  assign store_re   = accept && ctl.eligible;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_tolerance <= TOL_RESET;
      reuse_limit     <= REUSE_RESET;
      delta_limit     <= DELTA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MATCH_TOL: match_tolerance <= cfg_data;
        CFG_REUSE_THR: reuse_limit     <= cfg_data[ThrW-1:0];
        CFG_DELTA_THR: delta_limit     <= cfg_data[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the run position on every beat; drop back to zero at the run end
  always_ff @(posedge clk) begin
    if (rst) begin
      run_index <= '0;
    end else if (accept) begin
      run_index <= elem.last ? '0 : count_next;
    end
  end

  // Close a commit run: record its length and mark the layer valid
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_valid <= '0;
      for (int i = 0; i < LAYER_COUNT; i++) begin
        reference_length[i] <= '0;
      end
    end else if (accept && elem.kind && elem.last && layer_ok) begin
      reference_valid[layer_idx]  <= 1'b1;
      reference_length[layer_idx] <= count_next;
    end
  end

  drd_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_addr),
    .wdata (elem.value),
    .re    (store_re),
    .raddr (store_addr),
    .rdata (store_rdata)
  );

  drd_match #(
    .IW (IW)
  ) u_match (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .ld_ctl      (ctl),
    .ld_value    (elem.value),
    .ld_count    (count_next),
    .ref_value   (store_rdata),
    .tolerance   (match_tolerance),
    .take        (sum_take),
    .free        (elem_ready),
    .sum_valid   (sum_valid),
    .sum_matches (sum_matches),
    .sum_count   (sum_count),
    .sum_known   (sum_known)
  );

  drd_decide #(
    .IW (IW)
  ) u_decide (
    .clk          (clk),
    .rst          (rst),
    .sum_valid    (sum_valid),
    .sum_matches  (sum_matches),
    .sum_count    (sum_count),
    .sum_known    (sum_known),
    .reuse_limit  (reuse_limit),
    .delta_limit  (delta_limit),
    .take         (sum_take),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_index_bounded: assert property (@(posedge clk) disable iff (rst)
    run_index <= IW'(MAX_ELEMENTS))
    else $error("run position beyond store depth");

  a_run_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && elem.last) |=> (run_index == '0))
    else $error("run position not cleared after final beat");

  a_commit_marks: assert property (@(posedge clk) disable iff (rst)
    (accept && elem.kind && elem.last && layer_ok) |=> reference_valid[$past(layer_idx)])
    else $error("committed layer not marked valid");

endmodule
